>>> design/acm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package acm_pkg;

   localparam int NAME_LEN    = 10;
   localparam int ENTRIES     = 20;
   localparam int ENTRY_IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int POS_W       = 4;
   localparam int CMD_W       = 5;

   typedef logic [CMD_W-1:0] command_type;
   typedef logic [POS_W-1:0] pos_type;
   typedef logic [ENTRIES-1:0] entry_mask_type;

   localparam command_type CODE_SYNTAX     = 5'd0;
   localparam command_type CODE_DIR        = 5'd1;
   localparam command_type CODE_ASSIGN     = 5'd2;
   localparam command_type CODE_BLOCK      = 5'd3;
   localparam command_type CODE_COPY       = 5'd4;
   localparam command_type CODE_CD         = 5'd5;
   localparam command_type CODE_DUPLICATE  = 5'd6;
   localparam command_type CODE_INITIALIZE = 5'd7;
   localparam command_type CODE_MKDIR      = 5'd8;
   localparam command_type CODE_NEW        = 5'd9;
   localparam command_type CODE_POSITION   = 5'd10;
   localparam command_type CODE_RENAME     = 5'd11;
   localparam command_type CODE_RMDIR      = 5'd12;
   localparam command_type CODE_SCRATCH    = 5'd13;
   localparam command_type CODE_TIME       = 5'd14;
   localparam command_type CODE_UX         = 5'd15;
   localparam command_type CODE_VALIDATE   = 5'd16;
   localparam command_type CODE_EXT        = 5'd17;

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

   typedef logic [NAME_LEN*8-1:0] name_type;

   localparam name_type ENTRY_NAME [ENTRIES] = '{
      "ASSIGN    ", "BLOCK     ", "COPY      ", "CD        ", "CHDIR     ",
      "DUPLICATE ", "INITIALIZE", "M-        ", "MKDIR     ", "MD        ",
      "NEW       ", "P         ", "RENAME    ", "RMDIR     ", "RD        ",
      "SCRATCH   ", "TIME      ", "U         ", "VALIDATE  ", "X         "
   };

   localparam pos_type ENTRY_LEN [ENTRIES] = '{
      4'd6, 4'd5, 4'd4, 4'd2, 4'd5, 4'd9, 4'd10, 4'd2, 4'd5, 4'd2,
      4'd3, 4'd1, 4'd6, 4'd5, 4'd2, 4'd7, 4'd4, 4'd1, 4'd8, 4'd1
   };

   localparam command_type ENTRY_CODE [ENTRIES] = '{
      CODE_ASSIGN, CODE_BLOCK, CODE_COPY, CODE_CD, CODE_CD,
      CODE_DUPLICATE, CODE_INITIALIZE, CODE_SYNTAX, CODE_MKDIR, CODE_MKDIR,
      CODE_NEW, CODE_POSITION, CODE_RENAME, CODE_RMDIR, CODE_RMDIR,
      CODE_SCRATCH, CODE_TIME, CODE_UX, CODE_VALIDATE, CODE_EXT
   };

   typedef struct packed {
      logic [7:0] ch;
      logic       start_req;
   } req_type;

   typedef struct packed {
      command_type command;
      pos_type     length;
   } rsp_type;

   function automatic logic [7:0] entry_char(input int idx, input pos_type pos);
      logic [7:0] c;
      c = 8'h00;
      for (int p = 0; p < NAME_LEN; p++) begin
         if (pos == POS_W'(p)) begin
            c = ENTRY_NAME[idx][(NAME_LEN-1-p)*8 +: 8];
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

>>> design/abbreviated_command_matcher_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// A result is registered in the output register, visible the cycle after the character that decides it.
// One character per cycle while req_ready is high; all table entries are compared in parallel.
// The output register frees the input side whenever it is empty or being taken.
// Reset: all entries alive, position zero, waiting for a character with start_req.
module abbreviated_command_matcher_unit (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  acm_pkg::req_type   req_data,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output acm_pkg::rsp_type   rsp_data
);
   import acm_pkg::*;

   entry_mask_type alive_ff, alive_in;
   pos_type        pos_ff, pos_in;
   logic           decided_ff, decided_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_data_ff, rsp_data_in;

   entry_mask_type eff_alive, kept_alive;
   pos_type        eff_pos, next_pos;
   logic           eff_decided;
   logic           accept, alpha;
   logic           emit;
   rsp_type        result;
   logic           pre_found, post_found;
   logic [ENTRY_IDX_W-1:0] pre_idx, post_idx;
   pos_type        pre_len;

   assign accept    = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      eff_alive   = req_data.start_req ? {ENTRIES{1'b1}} : alive_ff;
      eff_pos     = req_data.start_req ? '0 : pos_ff;
      eff_decided = req_data.start_req ? 1'b0 : decided_ff;
      alpha = ((req_data.ch >= CHAR_UPPER_A) && (req_data.ch <= CHAR_UPPER_Z)) ||
              ((req_data.ch >= CHAR_LOWER_A) && (req_data.ch <= CHAR_LOWER_Z));
   end

   always_comb begin
      kept_alive = eff_alive;
      for (int i = 0; i < ENTRIES; i++) begin
         if (ENTRY_LEN[i] > eff_pos && entry_char(i, eff_pos) != req_data.ch) begin
            kept_alive[i] = 1'b0;
         end
      end
      next_pos = (eff_pos == {POS_W{1'b1}}) ? eff_pos : eff_pos + POS_W'(1);
   end

   always_comb begin
      pre_found  = 1'b0;
      pre_idx    = '0;
      post_found = 1'b0;
      post_idx   = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (eff_alive[i]) begin
            pre_found = 1'b1;
            pre_idx   = ENTRY_IDX_W'(i);
         end
         if (kept_alive[i]) begin
            post_found = 1'b1;
            post_idx   = ENTRY_IDX_W'(i);
         end
      end
      pre_len = (ENTRY_LEN[pre_idx] > eff_pos) ? eff_pos : ENTRY_LEN[pre_idx];
   end

   always_comb begin
      emit       = 1'b0;
      result     = '{command: CODE_SYNTAX, length: '0};
      alive_in   = alive_ff;
      pos_in     = pos_ff;
      decided_in = decided_ff;
      if (accept) begin
         alive_in   = eff_alive;
         pos_in     = eff_pos;
         decided_in = eff_decided;
         if (!eff_decided) begin
            if (eff_pos == '0 && req_data.ch == CHAR_DOLLAR) begin
               emit   = 1'b1;
               result = '{command: CODE_DIR, length: POS_W'(1)};
            end else if (!alpha) begin
               emit = 1'b1;
               if (pre_found && pre_len != '0) begin
                  result = '{command: ENTRY_CODE[pre_idx], length: pre_len};
               end
            end else begin
               alive_in = kept_alive;
               pos_in   = next_pos;
               if (!post_found) begin
                  emit = 1'b1;
               end else if (ENTRY_LEN[post_idx] <= next_pos) begin
                  emit   = 1'b1;
                  result = '{command: ENTRY_CODE[post_idx], length: ENTRY_LEN[post_idx]};
               end
            end
            if (emit) begin
               decided_in = 1'b1;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alive_ff     <= {ENTRIES{1'b1}};
         pos_ff       <= '0;
         decided_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         alive_ff     <= alive_in;
         pos_ff       <= pos_in;
         decided_ff   <= decided_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule
`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
   import acm_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   abbreviated_command_matcher_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   string word_table [ENTRIES] = '{
      "ASSIGN", "BLOCK", "COPY", "CD", "CHDIR", "DUPLICATE", "INITIALIZE", "M-",
      "MKDIR", "MD", "NEW", "P", "RENAME", "RMDIR", "RD", "SCRATCH", "TIME", "U",
      "VALIDATE", "X"
   };
   command_type word_code [ENTRIES] = '{
      CODE_ASSIGN, CODE_BLOCK, CODE_COPY, CODE_CD, CODE_CD, CODE_DUPLICATE,
      CODE_INITIALIZE, CODE_SYNTAX, CODE_MKDIR, CODE_MKDIR, CODE_NEW, CODE_POSITION,
      CODE_RENAME, CODE_RMDIR, CODE_RMDIR, CODE_SCRATCH, CODE_TIME, CODE_UX,
      CODE_VALIDATE, CODE_EXT
   };

   entry_mask_type live_mask = '1;
   pos_type        word_pos = '0;
   bit             word_done = 1'b1;

   rsp_type pending_matches [$];
   rsp_type want;
   int      errors = 0;
   int      sent_items = 0;
   bit      req_idle = 1'b1;
   bit      rsp_idle = 1'b1;

   function automatic bit is_letter(input logic [7:0] c);
      return (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
             (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z);
   endfunction

   function automatic int first_live();
      for (int i = 0; i < ENTRIES; i++) begin
         if (live_mask[i]) return i;
      end
      return -1;
   endfunction

   function automatic void predict_match(input req_type r, output bit produced,
                                         output rsp_type res);
      int w;
      int n;
      produced = 1'b0;
      res      = '0;
      if (r.start_req) begin
         live_mask = '1;
         word_pos  = '0;
         word_done = 1'b0;
      end
      if (word_done) begin
         return;
      end
      if (word_pos == 0 && r.ch == CHAR_DOLLAR) begin
         res = '{command: CODE_DIR, length: pos_type'(1)};
      end else if (!is_letter(r.ch)) begin
         w = first_live();
         res = '{command: CODE_SYNTAX, length: '0};
         if (w >= 0) begin
            n = word_table[w].len();
            if (n > word_pos) n = int'(word_pos);
            if (n != 0) res = '{command: word_code[w], length: pos_type'(n)};
         end
      end else begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (live_mask[i] && word_table[i].len() > word_pos &&
                word_table[i][word_pos] != r.ch)
               live_mask[i] = 1'b0;
         end
         if (word_pos < 15) word_pos = word_pos + pos_type'(1);
         w = first_live();
         if (w < 0) begin
            res = '{command: CODE_SYNTAX, length: '0};
         end else if (word_table[w].len() <= word_pos) begin
            res = '{command: word_code[w], length: pos_type'(word_table[w].len())};
         end else begin
            return;
         end
      end
      produced  = 1'b1;
      word_done = 1'b1;
   endfunction

   task automatic send_item(input logic [7:0] c, input logic s);
      req_type r;
      rsp_type res;
      bit produced;
      r = '{ch: c, start_req: s};
      while (req_idle && $urandom_range(0, 99) < 19) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      predict_match(r, produced, res);
      if (produced) pending_matches.push_back(res);
      sent_items++;
   endtask

   task automatic send_text(input string s, input logic [7:0] term);
      for (int i = 0; i < s.len(); i++) send_item(s[i], i == 0);
      send_item(term, 1'b0);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_matches.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   function automatic logic [7:0] rand_nonletter();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (is_letter(c));
      return c;
   endfunction

   function automatic logic [7:0] rand_letter();
      logic [7:0] c;
      c = 8'($urandom_range(CHAR_UPPER_A, CHAR_UPPER_Z));
      if ($urandom_range(0, 3) == 0) c = c + 8'd32;
      return c;
   endfunction

   task automatic test_dollar_and_empty();
      send_item("A", 1'b0);
      send_item("$", 1'b1);
      send_item(8'h00, 1'b1);
      send_item(8'hFF, 1'b1);
      send_item("Z", 1'b1);
      send_item("c", 1'b1);
   endtask

   task automatic test_abbreviations();
      send_text("INI", 8'h00);
      send_text("CD", "0");
      send_text("A", "@");
      send_text("M", "-");
      send_text("X", "0");
      send_text("R", "$");
   endtask

   task automatic test_dropped_and_ignored();
      send_item("B", 1'b1);
      send_item("P", 1'b1);
      send_item(8'h7B, 1'b0);
      send_item("q", 1'b0);
   endtask

   task automatic test_random_words(input int n_items);
      logic [7:0] word [$];
      int stop;
      int idx;
      int k;
      int pick;
      stop = sent_items + n_items;
      while (sent_items < stop) begin
         word = {};
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            idx = $urandom_range(0, ENTRIES - 1);
            k = $urandom_range(1, word_table[idx].len());
            for (int i = 0; i < k; i++) word.push_back(word_table[idx][i]);
            if ($urandom_range(0, 9) == 0) word[$urandom_range(0, k - 1)] = rand_letter();
            if ($urandom_range(0, 9) == 0 && is_letter(word[k - 1]))
               word[k - 1] = word[k - 1] | 8'h20;
            repeat ($urandom_range(0, 2)) word.push_back(rand_letter());
            word.push_back(rand_nonletter());
         end else if (pick < 70) begin
            word.push_back(CHAR_DOLLAR);
         end else if (pick < 80) begin
            word.push_back(rand_nonletter());
         end else if (pick < 90) begin
            repeat ($urandom_range(1, 12)) word.push_back(rand_letter());
            word.push_back(rand_nonletter());
         end else if (pick < 95) begin
            repeat ($urandom_range(1, 3)) word.push_back(rand_letter());
         end
         if (pick < 95) begin
            for (int i = 0; i < word.size(); i++) send_item(word[i], i == 0);
            repeat ($urandom_range(0, 2)) send_item(8'($urandom_range(0, 255)), 1'b0);
         end else begin
            repeat ($urandom_range(1, 6))
               send_item(8'($urandom_range(0, 255)), $urandom_range(0, 9) < 3);
         end
      end
   endtask

   task automatic test_pause_for_results();
      send_text("DUP", 8'h2E);
      wait_for_results();
      send_text("VALIDATE", 8'h20);
   endtask

   task automatic test_no_idle_stretch();
      req_idle = 1'b0;
      rsp_idle = 1'b0;
      test_random_words(400);
      req_idle = 1'b1;
      rsp_idle = 1'b1;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_matches.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual command %0d length %0d",
                     $time, rsp_data.command, rsp_data.length);
         end else begin
            want = pending_matches.pop_front();
            if (rsp_data.command !== want.command) begin
               errors++;
               $display("%0t: command mismatch, expected %0d, actual %0d",
                        $time, want.command, rsp_data.command);
            end
            if (rsp_data.length !== want.length) begin
               errors++;
               $display("%0t: length mismatch, expected %0d, actual %0d",
                        $time, want.length, rsp_data.length);
            end
         end
      end
      rsp_ready <= rsp_idle ? ($urandom_range(0, 99) >= 19) : 1'b1;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_dollar_and_empty();
      test_abbreviations();
      test_dropped_and_ignored();
      test_random_words(500);
      test_pause_for_results();
      test_no_idle_stretch();
      test_random_words(700);
      wait_for_results();
      repeat (8) @(posedge clock);
      if (errors == 0 && pending_matches.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

>>> sim.f
design/acm_pkg.sv
design/abbreviated_command_matcher_unit.sv
dv/tb.sv
